### hdl/scp_pkg.sv
// scp_pkg: types, fixed-point constants and helpers of the sine/cosine polynomial core
// working values are signed Q30; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

	localparam int ANGLE_W   = 24;
	localparam int OUT_W     = 18;
	localparam int WORK_FRAC = 30;
	localparam int OPA_W     = 32;
	localparam int VAL_W     = 34;
	localparam int MAG_W     = VAL_W - 1;
	localparam int PROD_W    = OPA_W + MAG_W;
	localparam int CL_W      = 32;
	localparam int REM_W     = 35;
	localparam int HSTEPS    = 5;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [OUT_W-1:0]   trig_t;
	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic        [MAG_W-1:0]   mag_t;
	typedef logic        [OPA_W-1:0]   opa_t;
	typedef logic        [PROD_W-1:0]  prod_t;
	typedef logic signed [CL_W-1:0]    cl_t;
	typedef logic        [REM_W-1:0]   rem_t;

	// pi/2 and pi with 32 fraction bits
	localparam logic [33:0] HALF_PI_Q32 = 34'd6746518852;
	localparam logic [33:0] PI_Q32      = 34'd13493037704;

	localparam val_t ONE_Q30 = 34'sd1073741824;
	localparam val_t S2      = -34'sd536870912;
	localparam val_t S4      = 34'sd44739243;
	localparam val_t S6      = -34'sd1491308;
	localparam val_t S8      = 34'sd26631;
	localparam val_t C1      = -34'sd1073741824;
	localparam val_t C3      = 34'sd178956971;
	localparam val_t C5      = -34'sd8947849;
	localparam val_t C7      = 34'sd213044;
	localparam val_t C9      = -34'sd2959;

	// horner: leading coefficient, then one addend per step; the sine lane has no addend in the last step
	localparam val_t SIN_LEAD = S8;
	localparam val_t COS_LEAD = C9;
	localparam val_t SIN_ADD [HSTEPS-1] = '{S6, S4, S2, ONE_Q30};
	localparam val_t COS_ADD [HSTEPS]   = '{C7, C5, C3, C1, 34'sd0};

	function automatic mag_t val_mag(input val_t v);
		return v[VAL_W-1] ? MAG_W'($unsigned(-v)) : MAG_W'($unsigned(v));
	endfunction

	// product magnitude back to Q30, half away from zero, sign reapplied
	function automatic val_t rnd_q30(input prod_t p, input logic neg);
		val_t q;
		q = val_t'((p + (PROD_W'(1) << (WORK_FRAC - 1))) >> WORK_FRAC);
		return neg ? -q : q;
	endfunction

	function automatic cl_t clamp_one(input val_t v);
		cl_t c;
		if (v > ONE_Q30) begin
			c = cl_t'(ONE_Q30);
		end else if (v < -ONE_Q30) begin
			c = -cl_t'(ONE_Q30);
		end else begin
			c = cl_t'(v);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/scp_if.sv
// scp_angle_if, scp_result_if: valid/ready channels of the sine/cosine polynomial core
// depends on scp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface scp_angle_if;
	import scp_pkg::*;
	logic   valid;
	logic   ready;
	angle_t angle;
	modport source(output valid, output angle, input ready);
	modport sink(input valid, input angle, output ready);
endinterface

interface scp_result_if;
	import scp_pkg::*;
	logic  valid;
	logic  ready;
	trig_t sine;
	trig_t cosine;
	modport source(output valid, output sine, output cosine, input ready);
	modport sink(input valid, input sine, input cosine, output ready);
endinterface

`default_nettype wire

### hdl/sine_cosine_polynomial_core.sv
// sine_cosine_polynomial_core: pipelined sine and cosine of a fixed-point angle
// range reduction by pi, horner polynomials in Q30, saturation and rounding
// depends on scp_pkg and scp_if
//
// usage
//   theta carries a signed Q7.16 angle in radians; trig returns sine and cosine in
//   signed Q1.16, saturated to plus or minus one. each transaction on theta gives
//   exactly one transaction on trig, in order.
//   twenty register stages: reduction by pi (reciprocal multiply, one correction),
//   r^2, five horner multiply/add steps in lockstep for both lanes (the sine lane
//   only passes through the fifth), then clamp and rounding into the output register.
//   throughput: one transaction per cycle while trig.ready is high; every stage
//   takes a new one whenever the stage after it can load.
//   reset clears every stage valid bit; payload registers are not reset.
//   stall: each stage holds while the next is full and held, empty stages keep
//   filling, so theta.ready falls only once every stage holds a transaction;
//   nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_polynomial_core #(
	parameter int ANGLE_FRAC_BITS  = 16,
	parameter int RESULT_FRAC_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	scp_angle_if.sink          theta,
	scp_result_if.source       trig
);
	import scp_pkg::*;

	localparam int NSTG    = 20;
	localparam int K       = 32 - ANGLE_FRAC_BITS;
	localparam int MQ_W    = ANGLE_W + K;
	localparam int RS      = 32;
	localparam int RECIP_W = K;
	localparam int N_W     = K - 7;
	localparam int RP_W    = RS + N_W;
	localparam int TP_W    = N_W + 34;
	localparam int SH      = WORK_FRAC - RESULT_FRAC_BITS;
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << (RS + K)) / PI_Q32);
	localparam logic [CL_W-1:0]    RND_R   = CL_W'(1) << (SH - 1);
	localparam rem_t               PI_R    = REM_W'(PI_Q32);
	localparam rem_t               HALF_R  = REM_W'(HALF_PI_Q32);
	localparam opa_t               RA_MAX  = OPA_W'((HALF_R + REM_W'(2)) >> 2);

	typedef struct packed {
		logic neg;
		logic par;
		logic rneg;
		opa_t ra;
		opa_t r2;
	} side_t;

	function automatic trig_t to_field(input cl_t v);
		logic [CL_W-1:0] m;
		logic [CL_W-1:0] q;
		logic [CL_W-1:0] f;
		m = v[CL_W-1] ? $unsigned(-v) : $unsigned(v);
		q = (m + RND_R) >> SH;
		f = v[CL_W-1] ? -q : q;
		return $signed(f[OUT_W-1:0]);
	endfunction

	// stage handshake
	logic [NSTG:1] vld_s;
	logic [NSTG:1] vup;
	logic [NSTG:1] ld;

	assign vup = {vld_s[NSTG-1:1], theta.valid};
	assign ld[NSTG] = ~vld_s[NSTG] | trig.ready;
	for (genvar k = 1; k < NSTG; k++) begin : g_ld
		assign ld[k] = ~vld_s[k] | ld[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld_s[k] <= vup[k];
				end
			end
		end
	end

	assign theta.ready = ld[1];

	// range reduction
	logic [ANGLE_W-1:0] mag_s1, mag_s2;
	logic               neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [RP_W-1:0]    rprod_s2;
	logic [N_W-1:0]     nest;
	logic [TP_W-1:0]    tprod;
	rem_t               mq_s3, t_s3, rem_s4, rem_s5;
	logic               par_s3, par_s4, par_s5, par_s6, par_s7;
	rem_t               rdist;
	opa_t               ra_s6, ra_s7;
	logic               rneg_s6, rneg_s7;
	logic [2*OPA_W-1:0] r2p_s7;
	side_t              side_s [8:18];

	assign nest  = rprod_s2[RS +: N_W];
	assign tprod = TP_W'(nest) * TP_W'(PI_Q32);
	assign rdist = (rem_s5 >= HALF_R) ? rem_s5 - HALF_R : HALF_R - rem_s5;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			neg_s1 <= theta.angle[ANGLE_W-1];
			mag_s1 <= theta.angle[ANGLE_W-1] ? $unsigned(-theta.angle) : $unsigned(theta.angle);
		end
		if (ld[2]) begin
			rprod_s2 <= RP_W'(mag_s1) * RP_W'(RECIP);
			mag_s2   <= mag_s1;
			neg_s2   <= neg_s1;
		end
		if (ld[3]) begin
			mq_s3  <= REM_W'(MQ_W'(mag_s2) << K);
			t_s3   <= tprod[REM_W-1:0];
			par_s3 <= nest[0];
			neg_s3 <= neg_s2;
		end
		if (ld[4]) begin
			rem_s4 <= mq_s3 - t_s3;
			par_s4 <= par_s3;
			neg_s4 <= neg_s3;
		end
		if (ld[5]) begin
			// quotient estimate may be one short
			rem_s5 <= (rem_s4 >= PI_R) ? rem_s4 - PI_R : rem_s4;
			par_s5 <= par_s4 ^ (rem_s4 >= PI_R);
			neg_s5 <= neg_s4;
		end
		if (ld[6]) begin
			ra_s6   <= OPA_W'((rdist + REM_W'(2)) >> 2);
			rneg_s6 <= rem_s5 < HALF_R;
			par_s6  <= par_s5;
			neg_s6  <= neg_s5;
		end
		if (ld[7]) begin
			r2p_s7  <= (2*OPA_W)'(ra_s6) * (2*OPA_W)'(ra_s6);
			ra_s7   <= ra_s6;
			rneg_s7 <= rneg_s6;
			par_s7  <= par_s6;
			neg_s7  <= neg_s6;
		end
		if (ld[8]) begin
			side_s[8].neg  <= neg_s7;
			side_s[8].par  <= par_s7;
			side_s[8].rneg <= rneg_s7;
			side_s[8].ra   <= ra_s7;
			side_s[8].r2   <= OPA_W'((r2p_s7 + ((2*OPA_W)'(1) << (WORK_FRAC - 1))) >> WORK_FRAC);
		end
	end

	for (genvar k = 9; k <= 18; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (ld[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// horner steps: multiply stage then round/add stage, both lanes in lockstep
	prod_t sin_prod_s [HSTEPS-1];
	logic  sin_pneg_s [HSTEPS-1];
	val_t  sin_hold_s17;
	val_t  sin_acc_s  [HSTEPS];
	prod_t cos_prod_s [HSTEPS];
	logic  cos_pneg_s [HSTEPS];
	val_t  cos_acc_s  [HSTEPS];

	for (genvar j = 0; j < HSTEPS; j++) begin : g_step
		localparam int MS = 9 + 2 * j;
		localparam int AS = 10 + 2 * j;
		mag_t cmag;
		logic cneg;

		if (j == 0) begin : g_clead
			assign cmag = val_mag(COS_LEAD);
			assign cneg = COS_LEAD[VAL_W-1];
		end else begin : g_cprev
			assign cmag = val_mag(cos_acc_s[j-1]);
			assign cneg = cos_acc_s[j-1][VAL_W-1];
		end

		if (j < HSTEPS - 1) begin : g_cpoly
			always_ff @(posedge clk) begin
				if (ld[MS]) begin
					cos_prod_s[j] <= PROD_W'(side_s[MS-1].r2) * PROD_W'(cmag);
					cos_pneg_s[j] <= cneg;
				end
			end
		end else begin : g_cr
			// final multiply by r itself
			always_ff @(posedge clk) begin
				if (ld[MS]) begin
					cos_prod_s[j] <= PROD_W'(side_s[MS-1].ra) * PROD_W'(cmag);
					cos_pneg_s[j] <= cneg ^ side_s[MS-1].rneg;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[AS]) begin
				cos_acc_s[j] <= rnd_q30(cos_prod_s[j], cos_pneg_s[j]) + COS_ADD[j];
			end
		end

		if (j < HSTEPS - 1) begin : g_sin
			mag_t smag;
			logic sneg;

			if (j == 0) begin : g_slead
				assign smag = val_mag(SIN_LEAD);
				assign sneg = SIN_LEAD[VAL_W-1];
			end else begin : g_sprev
				assign smag = val_mag(sin_acc_s[j-1]);
				assign sneg = sin_acc_s[j-1][VAL_W-1];
			end

			always_ff @(posedge clk) begin
				if (ld[MS]) begin
					sin_prod_s[j] <= PROD_W'(side_s[MS-1].r2) * PROD_W'(smag);
					sin_pneg_s[j] <= sneg;
				end
				if (ld[AS]) begin
					sin_acc_s[j] <= rnd_q30(sin_prod_s[j], sin_pneg_s[j]) + SIN_ADD[j];
				end
			end
		end else begin : g_sdelay
			always_ff @(posedge clk) begin
				if (ld[MS]) begin
					sin_hold_s17 <= sin_acc_s[j-1];
				end
				if (ld[AS]) begin
					sin_acc_s[j] <= sin_hold_s17;
				end
			end
		end
	end

	// clamp, quadrant and sign, then output rounding
	cl_t   sin_cl, cos_cl;
	cl_t   sin_s19, cos_s19;
	trig_t sin_s20, cos_s20;

	assign sin_cl = clamp_one(sin_acc_s[HSTEPS-1]);
	assign cos_cl = clamp_one(cos_acc_s[HSTEPS-1]);

	always_ff @(posedge clk) begin
		if (ld[19]) begin
			sin_s19 <= (side_s[18].par ^ side_s[18].neg) ? -sin_cl : sin_cl;
			cos_s19 <= side_s[18].par ? -cos_cl : cos_cl;
		end
		if (ld[20]) begin
			sin_s20 <= to_field(sin_s19);
			cos_s20 <= to_field(cos_s19);
		end
	end

	assign trig.valid  = vld_s[NSTG];
	assign trig.sine   = sin_s20;
	assign trig.cosine = cos_s20;

`ifndef SYNTHESIS
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NSTG-1] && !ld[NSTG] |=> vld_s[NSTG-1])
		else $error("stage before output lost its transaction under stall");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] |-> rem_s5 < PI_R)
		else $error("reduced angle not below pi");

	a_r_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[6] |-> ra_s6 <= RA_MAX)
		else $error("reduced argument beyond pi/2");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[19] |-> sin_s19 <= cl_t'(ONE_Q30) && sin_s19 >= -cl_t'(ONE_Q30) &&
		cos_s19 <= cl_t'(ONE_Q30) && cos_s19 >= -cl_t'(ONE_Q30))
		else $error("saturated value outside plus or minus one");
`endif

endmodule

`default_nettype wire
